@@ hw/rtl/slist_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slist_pkg: shared definitions for the sorted length list
// Sizes, command and status codes, and the control bundle that the list
// controller broadcasts to every storage cell of the chain.
// ----------------------------------------------------------------------------
package slist_pkg;

   // list size and derived widths
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // field widths of the request and response channels
   localparam int CMD_W    = 2;
   localparam int LENGTH_W = 32;
   localparam int TAG_W    = 16;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // request commands
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POS   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

   // operation applied by every cell on the same clock edge
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   // controller to cell broadcast
   typedef struct packed {
      cell_op_type         op;
      logic [LENGTH_W-1:0] new_length;
      logic [TAG_W-1:0]    new_tag;
      logic [POS_W-1:0]    del_pos;
      logic [CNT_W-1:0]    count;
      logic [LENGTH_W-1:0] wrap_length;
      logic [TAG_W-1:0]    wrap_tag;
   } cell_ctl_type;

   // controller state
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } list_state_type;

endpackage

@@ hw/rtl/slist_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slist_cell: one storage cell of the sorted chain
// Holds one length and tag. Takes the new entry, its left or right
// neighbor's entry, or the wrapped head entry as the broadcast op says.
// ----------------------------------------------------------------------------
module slist_cell (
   input  logic                          clock,
   input  slist_pkg::cell_ctl_type       ctl,
   input  logic [slist_pkg::IDX_W-1:0]   cell_idx,
   input  logic                          left_flag,
   input  logic [slist_pkg::LENGTH_W-1:0] left_length,
   input  logic [slist_pkg::TAG_W-1:0]   left_tag,
   input  logic [slist_pkg::LENGTH_W-1:0] right_length,
   input  logic [slist_pkg::TAG_W-1:0]   right_tag,
   output logic                          flag,
   output logic [slist_pkg::LENGTH_W-1:0] length,
   output logic [slist_pkg::TAG_W-1:0]   tag
);
   import slist_pkg::*;

   logic [LENGTH_W-1:0] length_ff, length_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic                occupied;
   logic                is_tail;
   logic                past_pos;

   // position of this cell against the list fill and the delete point
   assign occupied = CNT_W'(cell_idx) < ctl.count;
   assign is_tail  = (CNT_W'(cell_idx) + CNT_W'(1)) == ctl.count;
   assign past_pos = POS_W'(cell_idx) >= ctl.del_pos;

   // new entry goes at or before this cell (free cells always qualify)
   assign flag = !occupied || (length_ff >= ctl.new_length);

   // next entry of this cell
   always_comb begin
      length_in = length_ff;
      tag_in    = tag_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (left_flag) begin
               length_in = left_length;
               tag_in    = left_tag;
            end else if (flag) begin
               length_in = ctl.new_length;
               tag_in    = ctl.new_tag;
            end
         end
         CELL_DELETE: begin
            if (past_pos) begin
               length_in = right_length;
               tag_in    = right_tag;
            end
         end
         CELL_ROTATE: begin
            if (is_tail) begin
               length_in = ctl.wrap_length;
               tag_in    = ctl.wrap_tag;
            end else if (occupied) begin
               length_in = right_length;
               tag_in    = right_tag;
            end
         end
         default: begin
            length_in = length_ff;
            tag_in    = tag_ff;
         end
      endcase
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      length_ff <= length_in;
      tag_ff    <= tag_in;
   end

   assign length = length_ff;
   assign tag    = tag_ff;

endmodule

@@ hw/rtl/sorted_length_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_length_list: length-sorted entry list on a chain of cells
// Keeps up to DEPTH length/tag entries in ascending order of length and
// serves insert, delete, dump and count requests.
//
//   channel | ports                                    | direction
//   req     | req_valid, req_stall, req_cmd, req_new_* | in, stall out
//           | req_position                             |
//   rsp     | rsp_valid, rsp_stall, rsp_status,        | out, stall in
//           | rsp_entry_*, rsp_last                    |
//
// Insert, delete and count complete on the transfer: every cell updates in the cycle
// of the transfer and the response register loads at the same edge.
// During a dump the chain rotates one place per emitted entry and holds
// the request side stalled until the last one.
// Reset clears the fill count, the controller state and the response valid;
// the cell contents are not reset and are read only below the fill count.
// A stalled response holds the request side stalled as well.
// ----------------------------------------------------------------------------
module sorted_length_list (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [slist_pkg::CMD_W-1:0]     req_cmd,
   input  logic [slist_pkg::LENGTH_W-1:0]  req_new_length,
   input  logic [slist_pkg::TAG_W-1:0]     req_new_tag,
   input  logic [slist_pkg::POS_W-1:0]     req_position,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [slist_pkg::STATUS_W-1:0]  rsp_status,
   output logic [slist_pkg::LENGTH_W-1:0]  rsp_entry_length,
   output logic [slist_pkg::TAG_W-1:0]     rsp_entry_tag,
   output logic [slist_pkg::POS_W-1:0]     rsp_entry_position,
   output logic [slist_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic                            rsp_last
);
   import slist_pkg::*;

   list_state_type      state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    dump_idx_ff, dump_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [LENGTH_W-1:0] rsp_length_ff, rsp_length_in;
   logic [TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic                req_fire;
   logic                list_full;
   logic                list_empty;
   logic                pos_ok;
   logic                emit;
   logic                emit_last;

   cell_ctl_type        cell_ctl;
   logic                cell_flag   [DEPTH];
   logic [LENGTH_W-1:0] cell_length [DEPTH];
   logic [TAG_W-1:0]    cell_tag    [DEPTH];
   logic                left_flag   [DEPTH];
   logic [LENGTH_W-1:0] left_length [DEPTH];
   logic [TAG_W-1:0]    left_tag    [DEPTH];
   logic [LENGTH_W-1:0] right_length[DEPTH];
   logic [TAG_W-1:0]    right_tag   [DEPTH];

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign req_fire  = req_valid && !req_stall;

   // list status
   assign list_full  = count_ff == CNT_W'(DEPTH);
   assign list_empty = count_ff == CNT_W'(0);
   assign pos_ok     = COUNT_W'(req_position) < COUNT_W'(count_ff);

   // dump emission
   assign emit      = (state_ff == ST_DUMP) && out_free;
   assign emit_last = (CNT_W'(dump_idx_ff) + CNT_W'(1)) == count_ff;

   // broadcast to the cells
   always_comb begin
      cell_ctl.op          = CELL_HOLD;
      cell_ctl.new_length  = req_new_length;
      cell_ctl.new_tag     = req_new_tag;
      cell_ctl.del_pos     = req_position;
      cell_ctl.count       = count_ff;
      cell_ctl.wrap_length = cell_length[0];
      cell_ctl.wrap_tag    = cell_tag[0];
      if (req_fire && (req_cmd == CMD_INSERT) && !list_full) begin
         cell_ctl.op = CELL_INSERT;
      end else if (req_fire && (req_cmd == CMD_DELETE) && !list_empty && pos_ok) begin
         cell_ctl.op = CELL_DELETE;
      end else if (emit) begin
         cell_ctl.op = CELL_ROTATE;
      end
   end

   // neighbor wiring along the chain
   for (genvar g = 0; g < DEPTH; g++) begin : g_link
      if (g == 0) begin : g_head
         assign left_flag[g]   = 1'b0;
         assign left_length[g] = req_new_length;
         assign left_tag[g]    = req_new_tag;
      end else begin : g_left
         assign left_flag[g]   = cell_flag[g-1];
         assign left_length[g] = cell_length[g-1];
         assign left_tag[g]    = cell_tag[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign right_length[g] = cell_length[g];
         assign right_tag[g]    = cell_tag[g];
      end else begin : g_right
         assign right_length[g] = cell_length[g+1];
         assign right_tag[g]    = cell_tag[g+1];
      end
   end

   // cell chain
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      slist_cell u_cell (
         .clock        (clock),
         .ctl          (cell_ctl),
         .cell_idx     (IDX_W'(g)),
         .left_flag    (left_flag[g]),
         .left_length  (left_length[g]),
         .left_tag     (left_tag[g]),
         .right_length (right_length[g]),
         .right_tag    (right_tag[g]),
         .flag         (cell_flag[g]),
         .length       (cell_length[g]),
         .tag          (cell_tag[g])
      );
   end

   // controller and response register next values
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dump_idx_in   = dump_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      if (req_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_length_in = '0;
         rsp_tag_in    = '0;
         rsp_pos_in    = '0;
         rsp_count_in  = COUNT_W'(count_ff);
         rsp_last_in   = 1'b1;
         case (req_cmd)
            CMD_INSERT: begin
               if (list_full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  count_in     = count_ff + CNT_W'(1);
                  rsp_count_in = COUNT_W'(count_ff + CNT_W'(1));
               end
            end
            CMD_DELETE: begin
               if (list_empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else if (!pos_ok) begin
                  rsp_status_in = STATUS_BAD_POS;
               end else begin
                  count_in     = count_ff - CNT_W'(1);
                  rsp_count_in = COUNT_W'(count_ff - CNT_W'(1));
               end
            end
            CMD_DUMP: begin
               if (list_empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_DUMP;
                  dump_idx_in  = '0;
               end
            end
            CMD_COUNT: begin
               rsp_status_in = STATUS_OK;
            end
            default: begin
               rsp_status_in = STATUS_OK;
            end
         endcase
      end else if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_length_in = cell_length[0];
         rsp_tag_in    = cell_tag[0];
         rsp_pos_in    = POS_W'(dump_idx_ff);
         rsp_count_in  = COUNT_W'(count_ff);
         rsp_last_in   = emit_last;
         dump_idx_in   = dump_idx_ff + IDX_W'(1);
         if (emit_last) begin
            state_in = ST_IDLE;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dump_idx_ff   <= dump_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_length   = rsp_length_ff;
   assign rsp_entry_tag      = rsp_tag_ff;
   assign rsp_entry_position = rsp_pos_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_last           = rsp_last_ff;

   // fill count never passes the list size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above list size");

   // no request transfer while a dump is running
   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |-> req_stall)
      else $error("request taken during dump");

   // fill count moves only on a request transfer
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff))
      else $error("fill count changed without a transfer");

   // final dump entry returns the controller to idle
   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_last) |=> (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("dump did not end on its last entry");

endmodule
